// ===== rtl/core/molecule_placement_overlap_check_unit_macros.svh =====
// Assertion macros shared by the overlap check unit modules.
`ifndef MOLECULE_PLACEMENT_OVERLAP_CHECK_UNIT_MACROS_SVH
`define MOLECULE_PLACEMENT_OVERLAP_CHECK_UNIT_MACROS_SVH
`ifndef SYNTH
// Clocked property, disabled while reset is low.
`define MPOC_ASSERT(lbl, clk_i, rst_ni, prop_i, msg_i) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop_i) else $error(msg_i);
// Condition that must never hold at a clock edge.
`define MPOC_ASSERT_NEVER(lbl, clk_i, rst_ni, cond_i, msg_i) \
  `MPOC_ASSERT(lbl, clk_i, rst_ni, !(cond_i), msg_i)
`else
`define MPOC_ASSERT(lbl, clk_i, rst_ni, prop_i, msg_i)
`define MPOC_ASSERT_NEVER(lbl, clk_i, rst_ni, cond_i, msg_i)
`endif
`endif

// ===== rtl/core/mpoc_pkg.sv =====
// Types and constants shared by the overlap check unit modules.
`default_nettype none

package mpoc_pkg;

  localparam int COORD_W     = 16;
  localparam int ELEM_W      = 3;
  localparam int CNT_W       = 8;
  localparam int MIN_DIST_W  = 15;
  localparam int MAX_UNITS_W = 8;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_UNITS = 1'b1;

  // Configuration reset values
  localparam logic [MIN_DIST_W-1:0]  MIN_DIST_RST  = 15'd640;
  localparam logic [MAX_UNITS_W-1:0] MAX_UNITS_RST = 8'd33;

  typedef enum logic [1:0] {
    ST_ACCEPT    = 2'd0,
    ST_TOO_CLOSE = 2'd1,
    ST_FULL      = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [ELEM_W-1:0]         element;
    logic                      last_atom;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  units_total;
    logic [CNT_W-1:0]  stored_atoms;
  } out_item_t;

  // One stored atom
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [ELEM_W-1:0]         element;
  } atom_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic pipe_busy;
    logic last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mpoc_ctrl.sv =====
// Controller state machine: sequences load, store scan and decision per transaction.
`default_nettype none
`include "molecule_placement_overlap_check_unit_macros.svh"

module mpoc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start_i,
  output logic                 busy_o,
  output logic                 out_strobe_o,
  output mpoc_pkg::dp_cmd_t    cmd_o,
  input  wire mpoc_pkg::dp_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_strobe_r, out_strobe_nxt;
  logic   accept;

  // Decode commands and next state
  always_comb begin
    accept     = start_i && !busy_r;
    cmd_o.load   = accept;
    cmd_o.scan   = (state_r == S_SCAN) && !sts_i.scan_done;
    cmd_o.finish = (state_r == S_FINISH);
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_done && !sts_i.pipe_busy) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt       = (state_nxt != S_IDLE);
    out_strobe_nxt = (state_r == S_FINISH) && sts_i.last;
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= busy_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  assign busy_o       = busy_r;
  assign out_strobe_o = out_strobe_r;

  `MPOC_ASSERT(a_strobe_after_finish, clk, rst_n, out_strobe_r |-> $past(state_r == S_FINISH), "result strobe without a decision cycle")
  `MPOC_ASSERT(a_accept_starts_scan, clk, rst_n, (start_i && !busy_r) |=> (busy_r && state_r == S_SCAN), "accepted transaction did not start a scan")
  `MPOC_ASSERT_NEVER(a_finish_pipe_empty, clk, rst_n, (state_r == S_FINISH) && sts_i.pipe_busy, "decision taken while compare pipeline busy")

endmodule

`default_nettype wire

// ===== rtl/core/mpoc_datapath.sv =====
// Datapath: atom store, distance compare pipeline, unit bookkeeping and result register.
`default_nettype none
`include "molecule_placement_overlap_check_unit_macros.svh"

module mpoc_datapath #(
  parameter int STORE_DEPTH    = 128,
  parameter int MAX_UNIT_ATOMS = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mpoc_pkg::in_item_t                in_atom_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [mpoc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mpoc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire mpoc_pkg::dp_cmd_t                 cmd_i,
  output mpoc_pkg::dp_sts_t                      sts_o,
  output mpoc_pkg::out_item_t                    out_result_o
);

  localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ACW   = $clog2(STORE_DEPTH + 1);
  localparam int FW    = $clog2(MAX_UNIT_ATOMS + 1);
  localparam int PW    = ((ACW > FW) ? ACW : FW) + 1;
  localparam int CW    = mpoc_pkg::COORD_W;
  localparam int SQ_W  = 2 * CW;
  localparam int SUM_W = SQ_W + 2;
  localparam int LIM_W = 2 * mpoc_pkg::MIN_DIST_W;

  // Magnitude of the difference of two signed coordinates
  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    if (d[CW]) d = ~d + 1'b1;
    return d[CW-1:0];
  endfunction

  // Configuration and derived limit
  logic [mpoc_pkg::MIN_DIST_W-1:0]  sep_min_r;
  logic [mpoc_pkg::MAX_UNITS_W-1:0] max_units_r;
  logic [LIM_W-1:0]                 lim_r;

  // Current atom and scan
  mpoc_pkg::in_item_t cur_r;
  logic [ACW-1:0]     scan_addr_r;

  // Store
  mpoc_pkg::atom_t    store_mem [STORE_DEPTH];
  mpoc_pkg::atom_t    rd_data_r;
  mpoc_pkg::atom_t    wr_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;

  // Compare pipeline
  logic               v1_r, v2_r, v3_r;
  logic [CW-1:0]      mag_x_r, mag_y_r, mag_z_r;
  logic [SQ_W-1:0]    sq_x_r, sq_y_r, sq_z_r;
  logic [SUM_W-1:0]   dist_sum;
  logic               close;

  // Unit bookkeeping
  logic [ACW-1:0]     atom_count_r;
  logic [mpoc_pkg::CNT_W-1:0] unit_count_r;
  logic [FW-1:0]      unit_fill_r;
  logic               conflict_flag_r;
  logic               overflow_flag_r;
  mpoc_pkg::out_item_t out_res_r;

  // Decision terms
  logic               room;
  logic [FW-1:0]      fill_new;
  logic               ovf_new;
  logic [PW-1:0]      wr_sum;
  logic [PW-1:0]      end_sum;
  logic               store_full;
  logic               unit_limit;
  logic               decide;
  mpoc_pkg::status_t  status;

  // Write configuration registers and track the squared limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_min_r   <= mpoc_pkg::MIN_DIST_RST;
      max_units_r <= mpoc_pkg::MAX_UNITS_RST;
      lim_r       <= LIM_W'(mpoc_pkg::MIN_DIST_RST) * LIM_W'(mpoc_pkg::MIN_DIST_RST);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mpoc_pkg::CFG_MIN_DIST:  sep_min_r   <= cfg_wdata_i[mpoc_pkg::MIN_DIST_W-1:0];
          mpoc_pkg::CFG_MAX_UNITS: max_units_r <= cfg_wdata_i[mpoc_pkg::MAX_UNITS_W-1:0];
          default: ;
        endcase
      end
      lim_r <= LIM_W'(sep_min_r) * LIM_W'(sep_min_r);
    end
  end

  // Latch the incoming atom
  always_ff @(posedge clk) begin
    if (cmd_i.load) cur_r <= in_atom_i;
  end

  // Advance the scan address over the committed atoms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
    end else if (cmd_i.load) begin
      scan_addr_r <= '0;
    end else if (cmd_i.scan) begin
      scan_addr_r <= scan_addr_r + 1'b1;
    end
  end

  // Store the candidate atom behind the committed ones; refused units are simply not counted
  always_comb begin
    room     = (unit_fill_r < FW'(MAX_UNIT_ATOMS));
    fill_new = room ? (unit_fill_r + 1'b1) : unit_fill_r;
    ovf_new  = overflow_flag_r || !room;
    wr_sum   = PW'(atom_count_r) + PW'(unit_fill_r);
    end_sum  = PW'(atom_count_r) + PW'(fill_new);
    wr_en    = cmd_i.finish && room && (wr_sum < PW'(STORE_DEPTH));
    wr_addr  = wr_sum[AW-1:0];
    wr_data.x       = cur_r.pos_x;
    wr_data.y       = cur_r.pos_y;
    wr_data.z       = cur_r.pos_z;
    wr_data.element = cur_r.element;
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    if (cmd_i.scan) rd_data_r <= store_mem[scan_addr_r[AW-1:0]];
  end

  // Compare pipeline: differences, squares, sum and compare
  always_ff @(posedge clk) begin
    mag_x_r <= abs_diff(cur_r.pos_x, rd_data_r.x);
    mag_y_r <= abs_diff(cur_r.pos_y, rd_data_r.y);
    mag_z_r <= abs_diff(cur_r.pos_z, rd_data_r.z);
    sq_x_r  <= SQ_W'(mag_x_r) * SQ_W'(mag_x_r);
    sq_y_r  <= SQ_W'(mag_y_r) * SQ_W'(mag_y_r);
    sq_z_r  <= SQ_W'(mag_z_r) * SQ_W'(mag_z_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd_i.scan;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign dist_sum = SUM_W'(sq_x_r) + SUM_W'(sq_y_r) + SUM_W'(sq_z_r);
  assign close    = v3_r && (dist_sum < SUM_W'(lim_r));

  // Pick the decision, first matching check wins
  always_comb begin
    store_full = (end_sum > PW'(STORE_DEPTH));
    unit_limit = (unit_count_r >= max_units_r);
    decide     = cmd_i.finish && cur_r.last_atom;
    priority if (ovf_new) begin
      status = mpoc_pkg::ST_TOO_LARGE;
    end else if (unit_limit || store_full) begin
      status = mpoc_pkg::ST_FULL;
    end else if (conflict_flag_r) begin
      status = mpoc_pkg::ST_TOO_CLOSE;
    end else begin
      status = mpoc_pkg::ST_ACCEPT;
    end
  end

  // Update unit flags, counts and the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_count_r    <= '0;
      unit_count_r    <= '0;
      unit_fill_r     <= '0;
      conflict_flag_r <= 1'b0;
      overflow_flag_r <= 1'b0;
    end else begin
      if (close) conflict_flag_r <= 1'b1;
      if (decide) begin
        unit_fill_r     <= '0;
        conflict_flag_r <= 1'b0;
        overflow_flag_r <= 1'b0;
        if (status == mpoc_pkg::ST_ACCEPT) begin
          atom_count_r <= ACW'(end_sum);
          unit_count_r <= unit_count_r + 1'b1;
        end
      end else if (cmd_i.finish) begin
        unit_fill_r     <= fill_new;
        overflow_flag_r <= ovf_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      out_res_r.status <= status;
      if (status == mpoc_pkg::ST_ACCEPT) begin
        out_res_r.units_total  <= unit_count_r + 1'b1;
        out_res_r.stored_atoms <= mpoc_pkg::CNT_W'(end_sum);
      end else begin
        out_res_r.units_total  <= unit_count_r;
        out_res_r.stored_atoms <= mpoc_pkg::CNT_W'(atom_count_r);
      end
    end
  end

  assign sts_o.scan_done = (scan_addr_r == atom_count_r);
  assign sts_o.pipe_busy = v1_r || v2_r || v3_r;
  assign sts_o.last      = cur_r.last_atom;
  assign out_result_o    = out_res_r;

  `MPOC_ASSERT(a_decision_clears, clk, rst_n, (cmd_i.finish && cur_r.last_atom) |=> (!conflict_flag_r && !overflow_flag_r && unit_fill_r == '0), "unit state not cleared after decision")
  `MPOC_ASSERT(a_count_holds, clk, rst_n, !cmd_i.finish |=> $stable(atom_count_r), "atom count changed outside a decision")
  `MPOC_ASSERT_NEVER(a_scan_bound, clk, rst_n, scan_addr_r > atom_count_r, "scan ran past committed atoms")

endmodule

`default_nettype wire

// ===== rtl/core/molecule_placement_overlap_check_unit.sv =====
// Top level of the molecule placement overlap check unit.
// Each atom transaction scans all N committed atoms, one store read per cycle, through a
// compare pipeline of store read, differences, squares and sum and compare: busy stays high
// from the accepting edge through the scan, the pipeline drain and the decision state.
// On a last atom the registered result strobe follows the decision state, high for one cycle.
// Synchronous active-low reset clears counts, flags and configuration; no clearing pass.
`default_nettype none

module molecule_placement_overlap_check_unit #(
  parameter int STORE_DEPTH    = 128,
  parameter int MAX_UNIT_ATOMS = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire mpoc_pkg::in_item_t                in_atom,
  output logic                                   out_strobe,
  output mpoc_pkg::out_item_t                    out_result,
  input  wire logic                              cfg_we,
  input  wire logic [mpoc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [mpoc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  mpoc_pkg::dp_cmd_t cmd;
  mpoc_pkg::dp_sts_t sts;

  // Sequence each transaction
  mpoc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .out_strobe_o (out_strobe),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // Store, compare and decide
  mpoc_datapath #(
    .STORE_DEPTH    (STORE_DEPTH),
    .MAX_UNIT_ATOMS (MAX_UNIT_ATOMS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_atom_i    (in_atom),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_result_o (out_result)
  );

endmodule

`default_nettype wire

// ===== bench/molecule_placement_overlap_check_unit_checker.sv =====
// Checker for the overlap check unit: tracks placements, predicts decisions and compares them.
`timescale 1ns / 100ps

module molecule_placement_overlap_check_unit_checker #(
  parameter int STORE_DEPTH    = 128,
  parameter int MAX_UNIT_ATOMS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  mpoc_pkg::in_item_t                  in_atom,
  input  logic                                out_strobe,
  input  mpoc_pkg::out_item_t                 out_result,
  input  logic                                cfg_we,
  input  logic [mpoc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [mpoc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                  fail_count,
  output int                                  outstanding
);
  import mpoc_pkg::*;

  // Committed atoms and the molecule being assembled
  atom_t                  placed_atoms [STORE_DEPTH];
  atom_t                  cand_atoms   [MAX_UNIT_ATOMS];
  int                     n_atoms;
  int                     n_units;
  int                     cand_fill;
  bit                     cand_clash;
  bit                     cand_overflow;
  logic [MIN_DIST_W-1:0]  sep_min;
  logic [MAX_UNITS_W-1:0] unit_limit;
  out_item_t              decisions_due [$];
  int                     n_reports;

  // Flag a pair closer than the minimum separation, compared squared
  function automatic bit closer_than_limit(atom_t a, atom_t b);
    longint dx, dy, dz, lim;
    dx  = longint'(a.x) - longint'(b.x);
    dy  = longint'(a.y) - longint'(b.y);
    dz  = longint'(a.z) - longint'(b.z);
    lim = longint'(sep_min) * longint'(sep_min);
    return (dx * dx + dy * dy + dz * dz) < lim;
  endfunction

  // Advance the placement state by one atom; return 1 when a decision is due
  function automatic bit place_atom(input in_item_t it, output out_item_t decision);
    atom_t   a;
    status_t st;
    int      i;
    a.x       = it.pos_x;
    a.y       = it.pos_y;
    a.z       = it.pos_z;
    a.element = it.element;
    decision  = '0;
    for (i = 0; i < n_atoms; i++) begin
      if (closer_than_limit(a, placed_atoms[i])) cand_clash = 1'b1;
    end
    // Buffer up to the unit size, mark anything beyond it
    if (cand_fill < MAX_UNIT_ATOMS) begin
      cand_atoms[cand_fill] = a;
      cand_fill++;
    end else begin
      cand_overflow = 1'b1;
    end
    if (!it.last_atom) return 1'b0;
    // Decide in priority order: too large, limit or full, too close, accept
    if (cand_overflow) begin
      st = ST_TOO_LARGE;
    end else if (n_units >= int'(unit_limit) || n_atoms + cand_fill > STORE_DEPTH) begin
      st = ST_FULL;
    end else if (cand_clash) begin
      st = ST_TOO_CLOSE;
    end else begin
      st = ST_ACCEPT;
      for (i = 0; i < cand_fill; i++) placed_atoms[n_atoms + i] = cand_atoms[i];
      n_atoms += cand_fill;
      n_units++;
    end
    cand_fill     = 0;
    cand_clash    = 1'b0;
    cand_overflow = 1'b0;
    decision.status       = st;
    decision.units_total  = n_units[CNT_W-1:0];
    decision.stored_atoms = n_atoms[CNT_W-1:0];
    return 1'b1;
  endfunction

  // Compare the result first, then take the new transaction of the same edge
  always @(posedge clk) begin
    out_item_t due;
    out_item_t got;
    if (!rst_n) begin
      n_atoms       = 0;
      n_units       = 0;
      cand_fill     = 0;
      cand_clash    = 1'b0;
      cand_overflow = 1'b0;
      sep_min       = MIN_DIST_RST;
      unit_limit    = MAX_UNITS_RST;
      decisions_due.delete();
    end else begin
      if (out_strobe) begin
        got = out_result;
        if (decisions_due.size() == 0) begin
          fail_count++;
          if (n_reports < 10)
            $display("unexpected decision: status %0d units %0d atoms %0d",
                     got.status, got.units_total, got.stored_atoms);
          n_reports++;
        end else begin
          due = decisions_due.pop_front();
          if (got.status !== due.status || got.units_total !== due.units_total ||
              got.stored_atoms !== due.stored_atoms) begin
            fail_count++;
            if (n_reports < 10)
              $display("decision mismatch: status %0d/%0d units %0d/%0d atoms %0d/%0d",
                       due.status, got.status, due.units_total, got.units_total,
                       due.stored_atoms, got.stored_atoms);
            n_reports++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_MIN_DIST) sep_min = cfg_wdata[MIN_DIST_W-1:0];
        else if (cfg_idx == CFG_MAX_UNITS) unit_limit = cfg_wdata[MAX_UNITS_W-1:0];
      end
      if (start && !busy) begin
        if (place_atom(in_atom, due)) decisions_due = {decisions_due, due};
      end
    end
    outstanding = decisions_due.size();
  end

endmodule

// ===== bench/molecule_placement_overlap_check_unit_tb.sv =====
// Testbench top for the overlap check unit: clock, reset, atom stimulus and verdict.
`timescale 1ns / 100ps

module molecule_placement_overlap_check_unit_tb;
  import mpoc_pkg::*;

  localparam int STORE_DEPTH    = 128;
  localparam int MAX_UNIT_ATOMS = 4;
  localparam int DRAIN_CYCLES   = STORE_DEPTH + 8;
  localparam int CYCLE_LIMIT    = 600000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_atom;
  logic                  out_strobe;
  out_item_t             out_result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    outstanding;
  int                    cycle_count;
  int                    idle_pct;
  int                    sep_now;
  int                    random_sent;
  atom_t                 sent_atoms [$];

  molecule_placement_overlap_check_unit #(
    .STORE_DEPTH   (STORE_DEPTH),
    .MAX_UNIT_ATOMS(MAX_UNIT_ATOMS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_atom   (in_atom),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  molecule_placement_overlap_check_unit_checker #(
    .STORE_DEPTH   (STORE_DEPTH),
    .MAX_UNIT_ATOMS(MAX_UNIT_ATOMS)
  ) i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_atom    (in_atom),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Drive one atom transaction, with an optional gap first; returns at a falling edge
  task automatic send_atom(input int x, input int y, input int z, input int el,
                           input bit is_last);
    in_item_t it;
    atom_t    a;
    if ($urandom_range(99) < idle_pct) begin
      start   = 1'b0;
      in_atom = {$urandom(), 20'($urandom())};
      repeat ($urandom_range(1, 140)) @(negedge clk);
    end
    it.pos_x     = 16'(x);
    it.pos_y     = 16'(y);
    it.pos_z     = 16'(z);
    it.element   = 3'(el);
    it.last_atom = is_last;
    start   = 1'b1;
    in_atom = it;
    do @(posedge clk); while (busy);
    @(negedge clk);
    a.x       = it.pos_x;
    a.y       = it.pos_y;
    a.z       = it.pos_z;
    a.element = it.element;
    sent_atoms = {sent_atoms, a};
    if (sent_atoms.size() > 256) void'(sent_atoms.pop_front());
  endtask

  // Wait for the block to drain, then write both registers
  task automatic write_limits(input int min_d, input int max_u);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = CFG_MIN_DIST;
    cfg_wdata = CFG_DATA_W'(min_d);
    @(negedge clk);
    cfg_idx   = CFG_MAX_UNITS;
    cfg_wdata = CFG_DATA_W'(max_u);
    @(negedge clk);
    cfg_we  = 1'b0;
    sep_now = min_d;
  endtask

  // Full-range coordinate with the extremes mixed in
  function automatic int wide_coord();
    case ($urandom_range(15))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic int near_coord(input int c, input int r);
    return c + int'($urandom_range(2 * r)) - r;
  endfunction

  // Send one candidate molecule: some atoms huddle, some sit near earlier atoms
  task automatic send_molecule(input int n_atoms);
    int bx, by, bz, x, y, z, r, k, pick;
    r = (sep_now > 64) ? sep_now : 64;
    for (k = 0; k < n_atoms; k++) begin
      if (k > 0 && $urandom_range(1)) begin
        x = near_coord(bx, 512);
        y = near_coord(by, 512);
        z = near_coord(bz, 512);
      end else if (sent_atoms.size() != 0 && $urandom_range(99) < 35) begin
        pick = $urandom_range(sent_atoms.size() - 1);
        x = near_coord(int'(sent_atoms[pick].x), r);
        y = near_coord(int'(sent_atoms[pick].y), r);
        z = near_coord(int'(sent_atoms[pick].z), r);
      end else begin
        x = wide_coord();
        y = wide_coord();
        z = wide_coord();
      end
      if (k == 0) begin
        bx = x;
        by = y;
        bz = z;
      end
      send_atom(x, y, z, $urandom_range(7), k == n_atoms - 1);
      random_sent++;
    end
  endtask

  // Configure, then send whole molecules until the phase has enough atoms
  task automatic run_phase(input int min_d, input int max_u, input int n_items);
    int goal;
    write_limits(min_d, max_u);
    goal = random_sent + n_items;
    while (random_sent < goal) begin
      idle_pct = (random_sent < 140) ? 17 : (random_sent < 280) ? 46 : 0;
      if ($urandom_range(99) < 85) send_molecule($urandom_range(1, MAX_UNIT_ATOMS));
      else send_molecule($urandom_range(MAX_UNIT_ATOMS + 1, MAX_UNIT_ATOMS + 4));
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_atom     = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    idle_pct    = 17;
    sep_now     = MIN_DIST_RST;
    random_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty store, extremes, exact limit, conflicts
    send_atom(0, 0, 0, 0, 1'b1);
    send_atom(-32768, 32767, -32768, 7, 1'b1);
    send_atom(256, 0, 0, 1, 1'b1);
    send_atom(640, 0, 0, 2, 1'b1);
    send_atom(0, -639, 0, 3, 1'b1);
    // Candidate atoms close to each other are not compared
    send_atom(8000, 8000, 8000, 4, 1'b0);
    send_atom(8001, 8000, 8000, 5, 1'b1);
    // Full-size unit
    send_atom(-8000, -8000, -8000, 6, 1'b0);
    send_atom(-8000, -6000, -8000, 7, 1'b0);
    send_atom(-6000, -8000, -8000, 0, 1'b0);
    send_atom(-8000, -8000, -6000, 1, 1'b1);
    // Oversized unit with a conflict in it: size wins
    send_atom(1, 1, 1, 2, 1'b0);
    send_atom(20000, 0, 0, 3, 1'b0);
    send_atom(0, 20000, 0, 4, 1'b0);
    send_atom(0, 0, 20000, 5, 1'b0);
    send_atom(20000, 20000, 0, 6, 1'b1);
    // Largest separations
    send_atom(32767, -32768, 32767, 6, 1'b1);
    send_atom(32767, 32767, 32767, 7, 1'b1);
    // Zero minimum: an exact duplicate is accepted
    write_limits(0, 33);
    send_atom(0, 0, 0, 0, 1'b1);
    // Unit limit of zero: refusal beats conflict, size beats refusal
    write_limits(640, 0);
    send_atom(100, 100, 100, 1, 1'b1);
    send_atom(-20000, 5000, 5000, 2, 1'b0);
    send_atom(-20000, 9000, 5000, 3, 1'b0);
    send_atom(-20000, 5000, 9000, 4, 1'b0);
    send_atom(-24000, 5000, 5000, 5, 1'b0);
    send_atom(-24000, 9000, 9000, 6, 1'b1);

    // Random phases, ending with the store filled up
    run_phase($urandom_range(256, 2048), 0, 30);
    run_phase(32767, 128, 110);
    run_phase($urandom_range(300, 3000), $urandom_range(20, 60), 110);
    run_phase(0, 128, 170);

    // Drain and give the verdict
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== molecule_placement_overlap_check_unit.f =====
+incdir+rtl/core
rtl/core/mpoc_pkg.sv
rtl/core/mpoc_ctrl.sv
rtl/core/mpoc_datapath.sv
rtl/core/molecule_placement_overlap_check_unit.sv
bench/molecule_placement_overlap_check_unit_checker.sv
bench/molecule_placement_overlap_check_unit_tb.sv
